[design/ctc_pkg.sv]
// Shared types and constants for the contingency table counter.
package ctc_pkg;

  // Number of parent value fields carried by one item.
  localparam int NUM_PARENT_FIELDS = 4;
  // Largest number of parents that take part in the row index.
  localparam logic [2:0] MAX_PARENTS = 3'd4;

  // Operation carried in the slave-side tuser.
  typedef enum logic {
    OP_COUNT = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // Reason a transaction did not address a valid cell.
  typedef enum logic [1:0] {
    CAUSE_NONE           = 2'd0,
    CAUSE_PARENT_MISSING = 2'd1,
    CAUSE_OUT_OF_RANGE   = 2'd2
  } cause_t;

  // Register index on the configuration port.
  typedef enum logic [2:0] {
    REG_NUM_PARENTS      = 3'd0,
    REG_FACTOR_0         = 3'd1,
    REG_FACTOR_1         = 3'd2,
    REG_FACTOR_2         = 3'd3,
    REG_FACTOR_3         = 3'd4,
    REG_NODE_HAS_MISSING = 3'd5
  } reg_idx_t;

  // Configuration register contents.
  typedef struct packed {
    logic [2:0]                         num_parents;
    logic [NUM_PARENT_FIELDS-1:0][7:0]  factor;
    logic                               node_has_missing;
  } cfg_t;

  // One input item, all values kept as raw bits (sign is bit 4).
  typedef struct packed {
    op_t                                op;
    logic [4:0]                         node_value;
    logic [NUM_PARENT_FIELDS-1:0][4:0]  parent_value;
    logic [4:0]                         read_column;
    logic [7:0]                         read_row;
  } item_t;

  // Controller state.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_SUM,
    S_INDEX,
    S_READ,
    S_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic load;
    logic mul_en;
    logic sum_en;
    logic index_en;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

[design/ctc_regs.sv]
// Configuration register file behind the APB-style port.
module ctc_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output ctc_pkg::cfg_t      cfg
);

  ctc_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = ctc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ctc_pkg::REG_NUM_PARENTS:      cfg.num_parents      <= pwdata[2:0];
        ctc_pkg::REG_FACTOR_0:         cfg.factor[0]        <= pwdata[7:0];
        ctc_pkg::REG_FACTOR_1:         cfg.factor[1]        <= pwdata[7:0];
        ctc_pkg::REG_FACTOR_2:         cfg.factor[2]        <= pwdata[7:0];
        ctc_pkg::REG_FACTOR_3:         cfg.factor[3]        <= pwdata[7:0];
        ctc_pkg::REG_NODE_HAS_MISSING: cfg.node_has_missing <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data is the addressed register, zero elsewhere.
  always_comb begin
    unique case (idx)
      ctc_pkg::REG_NUM_PARENTS:      prdata = {29'd0, cfg.num_parents};
      ctc_pkg::REG_FACTOR_0:         prdata = {24'd0, cfg.factor[0]};
      ctc_pkg::REG_FACTOR_1:         prdata = {24'd0, cfg.factor[1]};
      ctc_pkg::REG_FACTOR_2:         prdata = {24'd0, cfg.factor[2]};
      ctc_pkg::REG_FACTOR_3:         prdata = {24'd0, cfg.factor[3]};
      ctc_pkg::REG_NODE_HAS_MISSING: prdata = {31'd0, cfg.node_has_missing};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

[design/ctc_ctrl.sv]
// Controller state machine: table clear sweep and per-transaction sequencing.
module ctc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ctc_pkg::stat_t  stat,
  output ctc_pkg::cmd_t   cmd
);

  ctc_pkg::state_t state;
  ctc_pkg::state_t state_next;

  // State register; reset starts the clear sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ctc_pkg::S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = ctc_pkg::S_IDLE;
        end
      end
      ctc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ctc_pkg::S_MUL;
        end
      end
      ctc_pkg::S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ctc_pkg::S_SUM;
      end
      ctc_pkg::S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ctc_pkg::S_INDEX;
      end
      ctc_pkg::S_INDEX: begin
        cmd.index_en = 1'b1;
        state_next   = ctc_pkg::S_READ;
      end
      ctc_pkg::S_READ: begin
        // The memory read data lands at the end of this cycle.
        state_next = ctc_pkg::S_COMMIT;
      end
      ctc_pkg::S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ctc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ctc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/ctc_dp.sv]
// Datapath: row index arithmetic, count memory and output register.
module ctc_dp #(
  parameter int TABLE_ROWS    = 256,
  parameter int TABLE_COLUMNS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  ctc_pkg::cfg_t    cfg,
  input  ctc_pkg::cmd_t    cmd,
  input  ctc_pkg::item_t   item,
  output ctc_pkg::stat_t   stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_count,
  output logic             out_skipped,
  output ctc_pkg::cause_t  out_cause
);

  localparam int RW    = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int CW    = $clog2(TABLE_COLUMNS);
  localparam int CELLS = TABLE_ROWS * TABLE_COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int NP    = ctc_pkg::NUM_PARENT_FIELDS;

  ctc_pkg::item_t             item_q;
  logic [NP-1:0][11:0]        prod;
  logic [NP-1:0][11:0]        prod_next;
  logic                       missing;
  logic                       missing_next;
  logic [5:0]                 col_sum;
  logic [2:0]                 used;
  logic [13:0]                row_sum;
  logic [31:0]                row_wide;
  logic [31:0]                col_wide;
  ctc_pkg::cause_t            cause_next;
  ctc_pkg::cause_t            cause;
  logic [RW-1:0]              row_idx;
  logic [CW-1:0]              col_idx;
  logic [AW-1:0]              addr;
  logic [AW-1:0]              clr_addr;
  logic [31:0]                mem [CELLS];
  logic [31:0]                rd_data;
  logic [31:0]                inc_data;
  logic                       do_write;

  // Input latch on an accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  // Number of parents in use, limited to the supported count.
  assign used = (cfg.num_parents > ctc_pkg::MAX_PARENTS) ? ctc_pkg::MAX_PARENTS
                                                         : cfg.num_parents;

  // Per-parent stride products and the missing flag over the used parents.
  always_comb begin
    missing_next = 1'b0;
    for (int i = 0; i < NP; i++) begin
      if ((3'(i) < used) && !item_q.parent_value[i][4]) begin
        prod_next[i] = 12'(cfg.factor[i]) * 12'(item_q.parent_value[i][3:0]);
      end else begin
        prod_next[i] = 12'd0;
      end
      if ((3'(i) < used) && item_q.parent_value[i][4]) begin
        missing_next = 1'b1;
      end
    end
  end

  // Stage one: register the products, missing flag and column.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod    <= prod_next;
      missing <= missing_next;
      col_sum <= {item_q.node_value[4], item_q.node_value} +
                 {5'd0, cfg.node_has_missing};
    end
  end

  // Stage two: row sum and range checks for both operations.
  always_comb begin
    row_sum = 14'(prod[0]) + 14'(prod[1]) + 14'(prod[2]) + 14'(prod[3]);
    if (item_q.op == ctc_pkg::OP_COUNT) begin
      row_wide = {18'd0, row_sum};
      col_wide = {27'd0, col_sum[4:0]};
      if (missing) begin
        cause_next = ctc_pkg::CAUSE_PARENT_MISSING;
      end else if (row_wide >= 32'(TABLE_ROWS) || col_sum[5] ||
                   col_wide >= 32'(TABLE_COLUMNS)) begin
        cause_next = ctc_pkg::CAUSE_OUT_OF_RANGE;
      end else begin
        cause_next = ctc_pkg::CAUSE_NONE;
      end
    end else begin
      row_wide = {24'd0, item_q.read_row};
      col_wide = {27'd0, item_q.read_column};
      if (row_wide >= 32'(TABLE_ROWS) || col_wide >= 32'(TABLE_COLUMNS)) begin
        cause_next = ctc_pkg::CAUSE_OUT_OF_RANGE;
      end else begin
        cause_next = ctc_pkg::CAUSE_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      row_idx <= row_wide[RW-1:0];
      col_idx <= col_wide[CW-1:0];
      cause   <= cause_next;
    end
  end

  // Stage three: flat cell address, row major.
  always_ff @(posedge clk) begin
    if (cmd.index_en) begin
      addr <= AW'(row_idx) * AW'(TABLE_COLUMNS) + AW'(col_idx);
    end
  end

  // Clear sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign stat.clear_last = (clr_addr == AW'(CELLS - 1));
  assign stat.out_free   = !out_valid || out_ready;

  // Saturating increment of the cell that was read.
  assign inc_data = (rd_data == 32'hFFFF_FFFF) ? rd_data : rd_data + 32'd1;
  assign do_write = cmd.commit && (item_q.op == ctc_pkg::OP_COUNT) &&
                    (cause == ctc_pkg::CAUSE_NONE);

  // Count memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[clr_addr] <= 32'd0;
    end else if (do_write) begin
      mem[addr] <= inc_data;
    end
    rd_data <= mem[addr];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_skipped <= (cause != ctc_pkg::CAUSE_NONE);
      out_cause   <= cause;
      if (cause != ctc_pkg::CAUSE_NONE) begin
        out_count <= 32'd0;
      end else if (item_q.op == ctc_pkg::OP_COUNT) begin
        out_count <= inc_data;
      end else begin
        out_count <= rd_data;
      end
    end
  end

endmodule

[design/contingency_table_counter.sv]
// Each accepted transaction runs products, row sum, address and a registered read of the
// count memory, then commits: a count that is not skipped does a saturating read-modify-write.
// A new transaction is taken only once the last has committed; a result that the master
// side has not taken holds the commit.
// Reset clears the registers and sweeps all TABLE_ROWS*TABLE_COLUMNS cells (8192 by
// default) to zero, one cell per cycle, with s_axis_tready held low.
module contingency_table_counter #(
  parameter int TABLE_ROWS    = 256,
  parameter int TABLE_COLUMNS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Slave side.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // node_value[4:0], parent_value_0[9:5], parent_value_1[14:10],
  // parent_value_2[19:15], parent_value_3[24:20], read_column[29:25],
  // read_row[37:30], zero fill [39:38]
  input  logic [39:0] s_axis_tdata,
  // op[0]
  input  logic [0:0]  s_axis_tuser,
  // Master side.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_count[31:0]
  output logic [31:0] m_axis_tdata,
  // skipped[0], skip_cause[2:1]
  output logic [2:0]  m_axis_tuser
);

  ctc_pkg::cfg_t   cfg;
  ctc_pkg::cmd_t   cmd;
  ctc_pkg::stat_t  stat;
  ctc_pkg::item_t  item;
  ctc_pkg::cause_t out_cause;
  logic            out_skipped;

  assign pready = 1'b1;

  // Unpack the incoming transaction.
  assign item.op              = ctc_pkg::op_t'(s_axis_tuser[0]);
  assign item.node_value      = s_axis_tdata[4:0];
  assign item.parent_value[0] = s_axis_tdata[9:5];
  assign item.parent_value[1] = s_axis_tdata[14:10];
  assign item.parent_value[2] = s_axis_tdata[19:15];
  assign item.parent_value[3] = s_axis_tdata[24:20];
  assign item.read_column     = s_axis_tdata[29:25];
  assign item.read_row        = s_axis_tdata[37:30];

  assign m_axis_tuser = {out_cause, out_skipped};

  ctc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ctc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ctc_dp #(
    .TABLE_ROWS    (TABLE_ROWS),
    .TABLE_COLUMNS (TABLE_COLUMNS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .item        (item),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_count   (m_axis_tdata),
    .out_skipped (out_skipped),
    .out_cause   (out_cause)
  );

  // Only one transaction is in flight at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new transaction accepted while one is in flight");

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");

  // A skipped transaction reports a zero count and a cause.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata == 32'd0 && m_axis_tuser[2:1] != ctc_pkg::CAUSE_NONE))
    else $error("skipped result with nonzero count or no cause");

  // No transaction is taken during the clear sweep.
  assert property (@(posedge clk) disable iff (rst)
    cmd.clear_en |-> !s_axis_tready)
    else $error("input ready during table clear");

endmodule
